>>> rtl/core/cylinder_signed_distance_macros.svh
// Assertion macros for the cylinder signed distance block
`ifndef CYLINDER_SIGNED_DISTANCE_MACROS_SVH
`define CYLINDER_SIGNED_DISTANCE_MACROS_SVH

// same-cycle implication, quiet during reset
`define CSD_ASSERT_SAME(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("csd assertion failed");

// next-cycle implication, quiet during reset
`define CSD_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("csd assertion failed");

`endif

>>> rtl/core/csd_pkg.sv
// Shared types and constants for the cylinder signed distance block
package csd_pkg;

  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned LEN_W      = 31;
  localparam int unsigned SQ1_W      = 68;
  localparam int unsigned SQ2_W      = 70;

  localparam logic [LEN_W-1:0] DIAM_RST = 31'd65536;
  localparam logic [LEN_W-1:0] LEN_RST  = 31'd65536;

  typedef enum logic [1:0] {
    REG_DIAMETER      = 2'd0,
    REG_LENGTH        = 2'd1,
    REG_CENTER_RADIAL = 2'd2,
    REG_CENTER_AXIAL  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [LEN_W-1:0] diameter;
    logic [LEN_W-1:0] length;
    logic             center_radial;
    logic             center_axial;
  } cfg_t;

endpackage

>>> rtl/core/csd_if.sv
// Request channel interfaces for points in and distances out
interface csd_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink (input valid, point_x, point_y, point_z, output ready);
endinterface

interface csd_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] distance;
  modport source (output valid, distance, input ready);
  modport sink (input valid, distance, output ready);
endinterface

>>> rtl/core/csd_sqrt.sv
// Pipelined integer square root, one result bit per stage, with sideband
module csd_sqrt #(
  parameter int unsigned RW = 68,
  parameter int unsigned SW = 35
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  logic [RW-1:0]     in_rad,
  input  logic [SW-1:0]     in_side,
  output logic              out_vld,
  output logic [RW/2-1:0]   out_root,
  output logic [SW-1:0]     out_side
);

  localparam int unsigned N = RW / 2;

  logic [RW-1:0] rem_r  [N];
  logic [RW-1:0] q_r    [N];
  logic [SW-1:0] side_r [N];
  logic          vld_r  [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam logic [RW-1:0] B = {{(RW-1){1'b0}}, 1'b1} << (2 * (N - 1 - k));
    logic [RW-1:0] rem_in, q_in, trial, rem_nxt, q_nxt;
    logic [SW-1:0] side_in;
    logic          vld_in, ge;

    if (k == 0) begin : g_first
      assign rem_in  = in_rad;
      assign q_in    = '0;
      assign side_in = in_side;
      assign vld_in  = in_vld;
    end else begin : g_rest
      assign rem_in  = rem_r[k-1];
      assign q_in    = q_r[k-1];
      assign side_in = side_r[k-1];
      assign vld_in  = vld_r[k-1];
    end

    always_comb begin
      trial   = q_in + B;
      ge      = rem_in >= trial;
      rem_nxt = ge ? rem_in - trial : rem_in;
      q_nxt   = ge ? (q_in >> 1) + B : q_in >> 1;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        q_r[k]    <= q_nxt;
        side_r[k] <= side_in;
      end
    end
  end

  assign out_vld  = vld_r[N-1];
  assign out_root = q_r[N-1][N-1:0];
  assign out_side = side_r[N-1];

endmodule

>>> rtl/core/csd_cfg.sv
// APB register file for the cylinder shape
module csd_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [csd_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [csd_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [csd_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  output csd_pkg::cfg_t                  cfg
);

  csd_pkg::cfg_t    cfg_r;
  csd_pkg::reg_idx_t idx;
  logic             wr;

  assign idx    = csd_pkg::reg_idx_t'(paddr[3:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.diameter      <= csd_pkg::DIAM_RST;
      cfg_r.length        <= csd_pkg::LEN_RST;
      cfg_r.center_radial <= 1'b0;
      cfg_r.center_axial  <= 1'b0;
    end else if (wr) begin
      case (idx)
        csd_pkg::REG_DIAMETER:      cfg_r.diameter      <= pwdata[30:0];
        csd_pkg::REG_LENGTH:        cfg_r.length        <= pwdata[30:0];
        csd_pkg::REG_CENTER_RADIAL: cfg_r.center_radial <= pwdata[0];
        csd_pkg::REG_CENTER_AXIAL:  cfg_r.center_axial  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      csd_pkg::REG_DIAMETER:      prdata = {1'b0, cfg_r.diameter};
      csd_pkg::REG_LENGTH:        prdata = {1'b0, cfg_r.length};
      csd_pkg::REG_CENTER_RADIAL: prdata = {31'd0, cfg_r.center_radial};
      csd_pkg::REG_CENTER_AXIAL:  prdata = {31'd0, cfg_r.center_axial};
      default:                    prdata = '0;
    endcase
  end

endmodule

>>> rtl/core/cylinder_signed_distance.sv
// Capped cylinder signed distance evaluator, axis along z.
// The pipeline from point request to distance request is made of the two
// bit-per-stage square root pipelines (34 and 35 stages) plus 7 arithmetic stages.
// Throughput: one point per cycle; a stalled output holds the whole pipeline.
// Reset (synchronous, active low) clears all valid bits and loads register defaults.
module cylinder_signed_distance (
  input  logic                           clk,
  input  logic                           rst_n,
  csd_in_if.sink                         in_if,
  csd_out_if.source                      out_if,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [csd_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [csd_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [csd_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);

`include "cylinder_signed_distance_macros.svh"

  csd_pkg::cfg_t cfg;
  logic          en;

  csd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  logic               out_vld_r;
  logic signed [31:0] dist_r;

  assign en          = !out_vld_r || out_if.ready;
  assign in_if.ready = en;

  // stage A: offsets, magnitudes, axial distance
  logic signed [34:0] off, x2, y2, z2, l2, lo, hi;
  logic        [32:0] mx_nxt, my_nxt;
  logic signed [34:0] da_nxt;
  logic               vld_a_r;
  logic        [32:0] mx_a_r, my_a_r;
  logic signed [34:0] da_a_r;

  always_comb begin
    off = cfg.center_radial ? 35'sd0 : $signed({4'd0, cfg.diameter});
    l2  = $signed({4'd0, cfg.length});
    x2  = $signed({{2{in_if.point_x[31]}}, in_if.point_x, 1'b0}) - off;
    y2  = $signed({{2{in_if.point_y[31]}}, in_if.point_y, 1'b0}) - off;
    z2  = $signed({{2{in_if.point_z[31]}}, in_if.point_z, 1'b0});
    if (cfg.center_axial) begin
      lo = -l2 - z2;
      hi = z2 - l2;
    end else begin
      lo = -z2;
      hi = z2 - (l2 <<< 1);
    end
    da_nxt = (lo > hi) ? lo : hi;
    mx_nxt = x2[34] ? 33'(-x2) : x2[32:0];
    my_nxt = y2[34] ? 33'(-y2) : y2[32:0];
  end

  // stage B: squares; stage C: sum
  logic               vld_b_r, vld_c_r;
  logic        [65:0] sqx_b_r, sqy_b_r;
  logic signed [34:0] da_b_r, da_c_r;
  logic        [66:0] sum_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
      vld_c_r <= 1'b0;
    end else if (en) begin
      vld_a_r <= in_if.valid;
      vld_b_r <= vld_a_r;
      vld_c_r <= vld_b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mx_a_r  <= mx_nxt;
      my_a_r  <= my_nxt;
      da_a_r  <= da_nxt;
      sqx_b_r <= mx_a_r * mx_a_r;
      sqy_b_r <= my_a_r * my_a_r;
      da_b_r  <= da_a_r;
      sum_c_r <= {1'b0, sqx_b_r} + {1'b0, sqy_b_r};
      da_c_r  <= da_b_r;
    end
  end

  logic                           vld_s1;
  logic [csd_pkg::SQ1_W/2-1:0]    root1;
  logic [34:0]                    da_s1;

  csd_sqrt #(.RW(csd_pkg::SQ1_W), .SW(35)) u_sqrt_radial (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (vld_c_r),
    .in_rad   ({1'b0, sum_c_r}),
    .in_side  (da_c_r),
    .out_vld  (vld_s1),
    .out_root (root1),
    .out_side (da_s1)
  );

  // stage D: radial distance; E: positive-part squares; F: sum
  logic               vld_d_r, vld_e_r, vld_f_r;
  logic signed [34:0] dr_d_r, da_d_r, mn_e_r, mn_f_r;
  logic        [67:0] sqr_e_r, sqa_e_r;
  logic        [68:0] sum_f_r;
  logic        [33:0] pr, pa;
  logic signed [34:0] mx_da, mn_nxt;

  always_comb begin
    pr     = dr_d_r > 35'sd0 ? dr_d_r[33:0] : 34'd0;
    pa     = da_d_r > 35'sd0 ? da_d_r[33:0] : 34'd0;
    mx_da  = dr_d_r > da_d_r ? dr_d_r : da_d_r;
    mn_nxt = mx_da < 35'sd0 ? mx_da : 35'sd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_d_r <= 1'b0;
      vld_e_r <= 1'b0;
      vld_f_r <= 1'b0;
    end else if (en) begin
      vld_d_r <= vld_s1;
      vld_e_r <= vld_d_r;
      vld_f_r <= vld_e_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dr_d_r  <= $signed({1'b0, root1}) - $signed({4'd0, cfg.diameter});
      da_d_r  <= $signed(da_s1);
      sqr_e_r <= pr * pr;
      sqa_e_r <= pa * pa;
      mn_e_r  <= mn_nxt;
      sum_f_r <= {1'b0, sqr_e_r} + {1'b0, sqa_e_r};
      mn_f_r  <= mn_e_r;
    end
  end

  logic                           vld_s2;
  logic [csd_pkg::SQ2_W/2-1:0]    root2;
  logic [34:0]                    mn_s2;

  csd_sqrt #(.RW(csd_pkg::SQ2_W), .SW(35)) u_sqrt_combine (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (vld_f_r),
    .in_rad   ({1'b0, sum_f_r}),
    .in_side  (mn_f_r),
    .out_vld  (vld_s2),
    .out_root (root2),
    .out_side (mn_s2)
  );

  // stage G: add interior part, round, saturate
  logic signed [36:0] s_sum;
  logic signed [35:0] q_val;
  logic signed [31:0] dist_nxt;

  always_comb begin
    s_sum = $signed({2'b00, root2}) + $signed({{2{mn_s2[34]}}, mn_s2}) + 37'sd1;
    q_val = 36'(s_sum >>> 1);
    if (q_val > 36'sd2147483647) begin
      dist_nxt = 32'sh7FFF_FFFF;
    end else if (q_val < -36'sd2147483648) begin
      dist_nxt = 32'sh8000_0000;
    end else begin
      dist_nxt = q_val[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= vld_s2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dist_r <= dist_nxt;
    end
  end

  assign out_if.valid    = out_vld_r;
  assign out_if.distance = dist_r;

  `CSD_ASSERT_SAME(a_stall_holds_input, clk, rst_n, out_if.valid && !out_if.ready, !in_if.ready)
  `CSD_ASSERT_SAME(a_empty_out_takes, clk, rst_n, !out_if.valid, in_if.ready)
  `CSD_ASSERT_NEXT(a_stall_freezes_out, clk, rst_n, out_if.valid && !out_if.ready, out_if.valid)

endmodule

>>> tb/csd_checker.sv
// Checker: predicts the distance for every point request and compares the results
`timescale 1ns / 100ps
module csd_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  csd_in_if                              in_if,
  csd_out_if                             out_if,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [csd_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [csd_pkg::CFG_DATA_W-1:0] pwdata,
  input  logic                           pready,
  output int                             fail_count,
  output int                             pending,
  output int                             matched
);

  csd_pkg::cfg_t      shape;
  logic signed [31:0] distance_q[$];

  function automatic logic [63:0] floor_root(logic [127:0] n);
    logic [63:0]  r;
    logic [127:0] t;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      t = {64'd0, r | (64'd1 << i)};
      if (t * t <= n) r = t[63:0];
    end
    return r;
  endfunction

  function automatic longint hypot_floor(longint a, longint b);
    logic [127:0] ma;
    logic [127:0] mb;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    return longint'(floor_root(ma * ma + mb * mb));
  endfunction

  function automatic logic signed [31:0] cylinder_distance(csd_pkg::cfg_t c,
                                                          logic signed [31:0] px,
                                                          logic signed [31:0] py,
                                                          logic signed [31:0] pz);
    longint d, l, off, x2, y2, z2, dr, da, lo, hi, s, q;
    d   = longint'(c.diameter);
    l   = longint'(c.length);
    off = c.center_radial ? 0 : d;
    x2  = 2 * longint'(px) - off;
    y2  = 2 * longint'(py) - off;
    z2  = 2 * longint'(pz);
    dr  = hypot_floor(x2, y2) - d;
    if (c.center_axial) begin
      lo = -l - z2;
      hi = z2 - l;
    end else begin
      lo = -z2;
      hi = z2 - 2 * l;
    end
    da = (lo > hi) ? lo : hi;
    s  = hypot_floor((dr > 0) ? dr : 0, (da > 0) ? da : 0);
    s  = s + (((dr > da ? dr : da) < 0) ? (dr > da ? dr : da) : 0) + 1;
    q  = (s >= 0) ? s / 2 : -((-s + 1) / 2);
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q[31:0];
  endfunction

  assign pending = distance_q.size();

  always @(posedge clk) begin
    logic signed [31:0] want;
    if (!rst_n) begin
      shape        <= '{diameter: csd_pkg::DIAM_RST, length: csd_pkg::LEN_RST,
                        center_radial: 1'b0, center_axial: 1'b0};
      distance_q.delete();
      fail_count   <= 0;
      matched      <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (distance_q.size() == 0) begin
          $display("%0t: distance request with none expected, actual %0d", $time,
                   out_if.distance);
          fail_count <= fail_count + 1;
        end else begin
          want = distance_q.pop_front();
          if (want !== out_if.distance) begin
            $display("%0t: distance mismatch, expected %0d actual %0d", $time, want,
                     out_if.distance);
            fail_count <= fail_count + 1;
          end else begin
            matched <= matched + 1;
          end
        end
      end
      if (in_if.valid && in_if.ready)
        distance_q.push_back(cylinder_distance(shape, in_if.point_x, in_if.point_y,
                                               in_if.point_z));
      if (psel && penable && pwrite && pready) begin
        case (csd_pkg::reg_idx_t'(paddr[3:2]))
          csd_pkg::REG_DIAMETER:      shape.diameter      <= pwdata[csd_pkg::LEN_W-1:0];
          csd_pkg::REG_LENGTH:        shape.length        <= pwdata[csd_pkg::LEN_W-1:0];
          csd_pkg::REG_CENTER_RADIAL: shape.center_radial <= pwdata[0];
          csd_pkg::REG_CENTER_AXIAL:  shape.center_axial  <= pwdata[0];
          default: ;
        endcase
      end
    end
  end
endmodule

>>> tb/tb_cylinder_signed_distance.sv
// Top of the cylinder signed distance testbench: stimulus, configuration and verdict
`timescale 1ns / 100ps
module tb_cylinder_signed_distance;

  localparam int STALL_LIMIT = 5000;

  logic                           clk;
  logic                           rst_n;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [csd_pkg::CFG_ADDR_W-1:0] paddr;
  logic [csd_pkg::CFG_DATA_W-1:0] pwdata;
  logic [csd_pkg::CFG_DATA_W-1:0] prdata;
  logic                           pready;
  logic                           steady;
  logic                           finished;
  int                             fail_count;
  int                             pending;
  int                             matched;
  int                             idle_cycles;
  int                             sent;
  int                             span;

  csd_in_if  in_if ();
  csd_out_if out_if ();

  cylinder_signed_distance u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  csd_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .out_if    (out_if),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .pready    (pready),
    .fail_count(fail_count),
    .pending   (pending),
    .matched   (matched)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  always @(negedge clk) begin
    if (!rst_n) out_if.ready <= 1'b0;
    else out_if.ready <= steady || ($urandom_range(0, 99) >= 18);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
        || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT && !finished) begin
      $display("%0t: no request moved for %0d cycles", $time, STALL_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(csd_pkg::reg_idx_t idx, logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_shape(logic [30:0] diam, logic [30:0] len, logic cr, logic ca);
    wait (pending == 0);
    in_if.valid <= 1'b0;
    write_reg(csd_pkg::REG_DIAMETER, {1'b0, diam});
    write_reg(csd_pkg::REG_LENGTH, {1'b0, len});
    write_reg(csd_pkg::REG_CENTER_RADIAL, {31'd0, cr});
    write_reg(csd_pkg::REG_CENTER_AXIAL, {31'd0, ca});
    span = (diam > len ? diam : len);
    if (span < 32'd65536) span = 65536;
    if (span > 32'h1fffffff) span = 32'h1fffffff;
  endtask

  task automatic send_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    while (!steady && $urandom_range(0, 99) < 18) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.point_x <= px;
    in_if.point_y <= py;
    in_if.point_z <= pz;
    do @(posedge clk); while (!in_if.ready);
    sent++;
    @(negedge clk);
  endtask

  function automatic logic [31:0] coord();
    if ($urandom_range(0, 99) < 25) return $urandom();
    return $urandom_range(0, 4 * span) - 2 * span;
  endfunction

  task automatic random_points(int n);
    repeat (n) send_point(coord(), coord(), coord());
    in_if.valid <= 1'b0;
  endtask

  initial begin
    rst_n         = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_if.valid   = 1'b0;
    in_if.point_x = '0;
    in_if.point_y = '0;
    in_if.point_z = '0;
    steady        = 1'b0;
    finished      = 1'b0;
    sent          = 0;
    span          = 65536;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    send_point(32'd0, 32'd0, 32'd0);
    send_point(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send_point(32'h80000000, 32'h80000000, 32'h80000000);
    send_point(32'h80000000, 32'h7fffffff, 32'h80000000);
    send_point(32'hffffffff, 32'hffffffff, 32'hffffffff);
    send_point(32'd32768, 32'd32768, 32'd32768);
    send_point(32'd65536, 32'd32768, 32'd65536);
    send_point(32'd32768, 32'd0, 32'd131072);
    random_points(70);

    set_shape(31'd0, 31'd0, 1'b0, 1'b0);
    send_point(32'd0, 32'd0, 32'd0);
    send_point(32'd1, 32'hffffffff, 32'd1);
    send_point(32'h80000000, 32'h80000000, 32'h7fffffff);
    random_points(50);

    set_shape(31'h7fffffff, 31'h7fffffff, 1'b1, 1'b1);
    send_point(32'd0, 32'd0, 32'd0);
    send_point(32'h7fffffff, 32'h80000000, 32'h7fffffff);
    send_point(32'h80000000, 32'd0, 32'h80000000);
    random_points(60);

    steady = 1'b1;
    set_shape(31'd262144, 31'd131072, 1'b1, 1'b0);
    send_point(32'd131072, 32'd0, 32'd65536);
    send_point(32'd0, 32'd0, 32'hffff0000);
    random_points(70);
    steady = 1'b0;

    set_shape(31'd65536, 31'd524288, 1'b0, 1'b1);
    send_point(32'd32768, 32'd32768, 32'd0);
    send_point(32'd32768, 32'd32768, 32'd262144);
    random_points(60);

    set_shape(31'($urandom()), 31'($urandom()), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)));
    random_points(60);

    wait (pending == 0);
    repeat (100) @(posedge clk);
    finished = 1'b1;
    $display("Sent %0d points over six cylinder shapes, %0d distances matched.", sent,
             matched);
    $display("Shapes covered zero and full-scale sizes, both centring options each way.");
    if (fail_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end
endmodule
